[design/tpes_pkg.sv]
// tpes_pkg: shared types, constants and helpers for the timed pin event sequencer
// no dependencies; imported by tpes_ctrl, tpes_dp and timed_pin_event_sequencer_core

package tpes_pkg;

	// list capacity and pin number width kept per event
	localparam int MAX_EVENTS = 16;
	localparam int PIN_BITS   = 6;

	// fixed field widths
	localparam int KIND_W  = 2;
	localparam int PIN_W   = 6;
	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 8;
	localparam int DRIVE_W = 2;

	// derived widths
	localparam int IDX_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
	localparam int PIN_KEEP_W = (PIN_BITS < PIN_W) ? PIN_BITS : PIN_W;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_REPEAT  = 1'b0;
	localparam logic REG_DEFAULT = 1'b1;

	// input word kinds
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd3;

	// drive codes
	localparam logic [DRIVE_W-1:0] DRIVE_LOW  = 2'd0;
	localparam logic [DRIVE_W-1:0] DRIVE_HIGH = 2'd1;
	localparam logic [DRIVE_W-1:0] DRIVE_PWM  = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;

	// controller to datapath commands
	typedef struct packed {
		logic append;
		logic start;
		logic tick;
		logic stop;
		logic fire;
		logic walk;
	} tpes_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic running;
		logic full;
		logic count_zero;
		logic due;
		logic fire_final;
		logic walk_final;
		logic repeat_en;
		logic out_free;
	} tpes_stat_t;

	// drive mode from a level
	function automatic logic [DRIVE_W-1:0] drive_of(input logic [LEVEL_W-1:0] lvl);
		logic [DRIVE_W-1:0] d;
		if (lvl == '0)
			d = DRIVE_LOW;
		else if (lvl == LEVEL_FULL)
			d = DRIVE_HIGH;
		else
			d = DRIVE_PWM;
		return d;
	endfunction

endpackage

[design/tpes_ctrl.sv]
// tpes_ctrl: sequencing state machine for the timed pin event sequencer
// depends on tpes_pkg; drives tpes_dp through command and status structs

module tpes_ctrl
	import tpes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  tpes_stat_t        stat,
	output tpes_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_FIRE  = 2'd2;
	localparam logic [1:0] ST_WALK  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// words are taken only between operations
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_APPEND: cmd.append = !stat.running && !stat.full;
						KIND_START:  cmd.start  = !stat.count_zero;
						KIND_TICK: begin
							if (stat.running) begin
								cmd.tick = 1'b1;
								state_d  = ST_CHECK;
							end
						end
						KIND_STOP: begin
							cmd.stop = 1'b1;
							if (!stat.count_zero)
								state_d = ST_WALK;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHECK: begin
				state_d = stat.due ? ST_FIRE : ST_IDLE;
			end
			ST_FIRE: begin
				if (stat.out_free) begin
					cmd.fire = 1'b1;
					state_d  = (stat.fire_final && !stat.repeat_en) ? ST_WALK : ST_IDLE;
				end
			end
			ST_WALK: begin
				if (stat.out_free) begin
					cmd.walk = 1'b1;
					if (stat.walk_final)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[design/tpes_dp.sv]
// tpes_dp: event store, counters, timer, configuration registers and output word
// depends on tpes_pkg; commanded by tpes_ctrl

module tpes_dp
	import tpes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tpes_cmd_t          cmd,
	output tpes_stat_t         stat,
	input  logic [PIN_W-1:0]   pin,
	input  logic [TIME_W-1:0]  event_time,
	input  logic [LEVEL_W-1:0] event_level,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIN_W-1:0]   pin_res,
	output logic [LEVEL_W-1:0] level,
	output logic [DRIVE_W-1:0] drive,
	output logic               is_end_write,
	output logic               last
);

	// event store, reset undefined
	logic [PIN_KEEP_W-1:0] ev_pin_q   [MAX_EVENTS];
	logic [TIME_W-1:0]     ev_time_q  [MAX_EVENTS];
	logic [LEVEL_W-1:0]    ev_level_q [MAX_EVENTS];

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   next_q;
	logic [CNT_W-1:0]   walk_q;
	logic               running_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic               repeat_q;
	logic [LEVEL_W-1:0] default_q;

	logic               out_valid_q;
	logic [PIN_W-1:0]   pin_res_q;
	logic [LEVEL_W-1:0] level_q;
	logic               end_write_q;
	logic               last_q;

	logic [CNT_W-1:0]   next_inc;
	logic [CNT_W-1:0]   walk_inc;
	logic [IDX_W-1:0]   next_idx;
	logic [IDX_W-1:0]   walk_idx;
	logic               cfg_write;

	assign next_inc = next_q + CNT_W'(1);
	assign walk_inc = walk_q + CNT_W'(1);
	assign next_idx = next_q[IDX_W-1:0];
	assign walk_idx = walk_q[IDX_W-1:0];

	// status back to the controller
	assign stat.running    = running_q;
	assign stat.full       = (count_q >= CNT_W'(MAX_EVENTS));
	assign stat.count_zero = (count_q == '0);
	assign stat.due        = (next_q < count_q) && (ev_time_q[next_idx] <= elapsed_q);
	assign stat.fire_final = (next_inc >= count_q);
	assign stat.walk_final = (walk_inc >= count_q);
	assign stat.repeat_en  = repeat_q;
	assign stat.out_free   = !out_valid_q || !out_stall;

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q  <= 1'b0;
			default_q <= '0;
		end else if (cfg_write) begin
			if (paddr[2] == REG_REPEAT)
				repeat_q <= pwdata[0];
			else
				default_q <= pwdata[LEVEL_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_REPEAT)
			prdata = PDATA_W'(repeat_q);
		else
			prdata = PDATA_W'(default_q);
	end

	// event store writes
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			ev_pin_q[count_q[IDX_W-1:0]]   <= pin[PIN_KEEP_W-1:0];
			ev_time_q[count_q[IDX_W-1:0]]  <= event_time;
			ev_level_q[count_q[IDX_W-1:0]] <= event_level;
		end
	end

	// list pointers, run flag and millisecond timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_q    <= '0;
			walk_q    <= '0;
			running_q <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (cmd.append)
				count_q <= count_q + CNT_W'(1);
			if (cmd.start) begin
				running_q <= 1'b1;
				next_q    <= '0;
				elapsed_q <= '0;
			end
			if (cmd.tick && (elapsed_q != '1))
				elapsed_q <= elapsed_q + TIME_W'(1);
			if (cmd.stop) begin
				running_q <= 1'b0;
				next_q    <= '0;
				elapsed_q <= '0;
				walk_q    <= '0;
			end
			if (cmd.fire) begin
				if (!stat.fire_final) begin
					next_q <= next_inc;
				end else begin
					next_q    <= '0;
					elapsed_q <= '0;
					if (!repeat_q) begin
						running_q <= 1'b0;
						walk_q    <= '0;
					end
				end
			end
			if (cmd.walk)
				walk_q <= walk_inc;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.fire || cmd.walk)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			pin_res_q   <= PIN_W'(ev_pin_q[next_idx]);
			level_q     <= ev_level_q[next_idx];
			end_write_q <= 1'b0;
			last_q      <= !(stat.fire_final && !repeat_q);
		end else if (cmd.walk) begin
			pin_res_q   <= PIN_W'(ev_pin_q[walk_idx]);
			level_q     <= default_q;
			end_write_q <= 1'b1;
			last_q      <= stat.walk_final;
		end
	end

	assign out_valid    = out_valid_q;
	assign pin_res      = pin_res_q;
	assign level        = level_q;
	assign drive        = drive_of(level_q);
	assign is_end_write = end_write_q;
	assign last         = last_q;

endmodule

[design/timed_pin_event_sequencer_core.sv]
// Timed pin event sequencer. Append words store up to MAX_EVENTS events (pin, time,
// level) while the sequence is not running; a start word rewinds and runs it, each
// tick word advances the millisecond timer and fires at most one due event as a pin
// write, and a stop word (or the last event without repeat) ends the run with one
// default-level write per stored event. Append, start and an empty stop complete in the
// idle state; a tick passes through a check state, and a fire state when an event is
// due; a stop walks the stored events, whose end writes leave one a cycle through the
// single output register unless the output side stalls. The next input word is
// accepted once the controller is back in idle, while the last result may still wait
// in the output register.
// depends on tpes_pkg, tpes_ctrl and tpes_dp

module timed_pin_event_sequencer_core
	import tpes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [PIN_W-1:0]   pin,
	input  logic [TIME_W-1:0]  event_time,
	input  logic [LEVEL_W-1:0] event_level,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIN_W-1:0]   pin_res,
	output logic [LEVEL_W-1:0] level,
	output logic [DRIVE_W-1:0] drive,
	output logic               is_end_write,
	output logic               last
);

	tpes_cmd_t  cmd;
	tpes_stat_t stat;

	// controller
	tpes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	tpes_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pin          (pin),
		.event_time   (event_time),
		.event_level  (event_level),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pin_res      (pin_res),
		.level        (level),
		.drive        (drive),
		.is_end_write (is_end_write),
		.last         (last)
	);

endmodule
